### rtl/core/afd_pkg.sv
package afd_pkg;

  localparam int AXIS_W   = 16;
  localparam int MAG_W    = 32;
  localparam int SQ_W     = 31;
  localparam int LIMIT_W  = 32;
  localparam int TICK_W   = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_MOTION_ENABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FREEFALL_SQ   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMPACT_SQ     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STILL_SQ_LOW  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STILL_SQ_HIGH = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_TIMEOUT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_STILL_HOLD    = 3'd6;

  localparam logic               RST_MOTION_ENABLE = 1'b1;
  localparam logic [LIMIT_W-1:0] RST_FREEFALL_SQ   = 32'd8220836;
  localparam logic [LIMIT_W-1:0] RST_IMPACT_SQ     = 32'd67108864;
  localparam logic [LIMIT_W-1:0] RST_STILL_SQ_LOW  = 32'd10737418;
  localparam logic [LIMIT_W-1:0] RST_STILL_SQ_HIGH = 32'd24159191;
  localparam logic [TICK_W-1:0]  RST_PHASE_TIMEOUT = 16'd25;
  localparam logic [TICK_W-1:0]  RST_STILL_HOLD    = 16'd50;

  typedef struct packed {
    logic                     op;
    logic signed [AXIS_W-1:0] accel_x;
    logic signed [AXIS_W-1:0] accel_y;
    logic signed [AXIS_W-1:0] accel_z;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]       phase;
    logic             fall_alarm;
    logic             fall_event;
    logic [MAG_W-1:0] mag_sq;
  } out_beat_t;

endpackage

### rtl/core/afd_chan_if.sv
interface afd_chan_if #(
  parameter type data_t = logic
);
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/accel_fall_detector.sv
// channel   dir  payload                                     beat when
// in_ch     in   op, accel_x, accel_y, accel_z               valid && ready
// out_ch    out  phase, fall_alarm, fall_event, mag_sq       valid && ready
// cfg_*     in   cfg_index, cfg_data                         cfg_we high
//
// one beat per cycle sustained while out_ch is ready; registers in order: input reg, square reg, sum reg,
// result reg where the phase machine updates
// rst_n synchronous active low: phase normal, counter and alarm zero, registers at defaults
// out_ch stalls back-pressure stage by stage; in_ch.ready stays high while any stage is empty
module accel_fall_detector #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  afd_chan_if.sink                        in_ch,
  afd_chan_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [afd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [afd_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int CMP_W = (COUNT_WIDTH > afd_pkg::TICK_W) ? COUNT_WIDTH : afd_pkg::TICK_W;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
  localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

  typedef enum logic [1:0] {
    PH_NORMAL = 2'd0,
    PH_FALL   = 2'd1,
    PH_IMPACT = 2'd2,
    PH_STILL  = 2'd3
  } phase_t;

  // configuration registers
  logic                            motion_enable_r;
  logic [afd_pkg::LIMIT_W-1:0]     freefall_sq_r;
  logic [afd_pkg::LIMIT_W-1:0]     impact_sq_r;
  logic [afd_pkg::LIMIT_W-1:0]     still_low_r;
  logic [afd_pkg::LIMIT_W-1:0]     still_high_r;
  logic [afd_pkg::TICK_W-1:0]      phase_timeout_r;
  logic [afd_pkg::TICK_W-1:0]      still_hold_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      motion_enable_r <= afd_pkg::RST_MOTION_ENABLE;
      freefall_sq_r   <= afd_pkg::RST_FREEFALL_SQ;
      impact_sq_r     <= afd_pkg::RST_IMPACT_SQ;
      still_low_r     <= afd_pkg::RST_STILL_SQ_LOW;
      still_high_r    <= afd_pkg::RST_STILL_SQ_HIGH;
      phase_timeout_r <= afd_pkg::RST_PHASE_TIMEOUT;
      still_hold_r    <= afd_pkg::RST_STILL_HOLD;
    end else if (cfg_we) begin
      case (cfg_index)
        afd_pkg::REG_MOTION_ENABLE: motion_enable_r <= cfg_data[0];
        afd_pkg::REG_FREEFALL_SQ:   freefall_sq_r   <= cfg_data;
        afd_pkg::REG_IMPACT_SQ:     impact_sq_r     <= cfg_data;
        afd_pkg::REG_STILL_SQ_LOW:  still_low_r     <= cfg_data;
        afd_pkg::REG_STILL_SQ_HIGH: still_high_r    <= cfg_data;
        afd_pkg::REG_PHASE_TIMEOUT: phase_timeout_r <= cfg_data[afd_pkg::TICK_W-1:0];
        afd_pkg::REG_STILL_HOLD:    still_hold_r    <= cfg_data[afd_pkg::TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline occupancy and per-stage ready
  logic s1_v_r, s2_v_r, s3_v_r, out_v_r;
  logic s1_rdy, s2_rdy, s3_rdy, out_rdy;

  assign out_rdy = !out_v_r || out_ch.ready;
  assign s3_rdy  = !s3_v_r || out_rdy;
  assign s2_rdy  = !s2_v_r || s3_rdy;
  assign s1_rdy  = !s1_v_r || s2_rdy;
  assign in_ch.ready = s1_rdy;

  afd_pkg::in_beat_t s1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_rdy) begin
      s1_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_rdy && in_ch.valid) begin
      s1_r <= in_ch.data;
    end
  end

  // squares
  logic signed [2*afd_pkg::AXIS_W-1:0] prod_x, prod_y, prod_z;
  logic [afd_pkg::SQ_W-1:0]            sq_x_r, sq_y_r, sq_z_r;
  logic                                s2_op_r;

  assign prod_x = s1_r.accel_x * s1_r.accel_x;
  assign prod_y = s1_r.accel_y * s1_r.accel_y;
  assign prod_z = s1_r.accel_z * s1_r.accel_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_rdy) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_rdy && s1_v_r) begin
      s2_op_r <= s1_r.op;
      sq_x_r  <= prod_x[afd_pkg::SQ_W-1:0];
      sq_y_r  <= prod_y[afd_pkg::SQ_W-1:0];
      sq_z_r  <= prod_z[afd_pkg::SQ_W-1:0];
    end
  end

  // sum
  logic [afd_pkg::MAG_W-1:0] mag_sum;
  logic [afd_pkg::MAG_W-1:0] s3_mag_r;
  logic                      s3_op_r;

  assign mag_sum = afd_pkg::MAG_W'(sq_x_r) + afd_pkg::MAG_W'(sq_y_r)
                 + afd_pkg::MAG_W'(sq_z_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (s3_rdy) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_rdy && s2_v_r) begin
      s3_op_r  <= s2_op_r;
      s3_mag_r <= mag_sum;
    end
  end

  // phase machine
  phase_t                    phase_r, phase_nxt;
  logic [COUNT_WIDTH-1:0]    tick_count_r, tick_count_nxt;
  logic                      alarm_r, alarm_nxt;
  logic                      event_nxt;
  logic [afd_pkg::MAG_W-1:0] mag_nxt;
  afd_pkg::out_beat_t        out_r;

  always_comb begin
    logic in_band;
    logic enter;
    logic timeout;
    logic hold_done;
    in_band   = (s3_mag_r >= still_low_r) && (s3_mag_r <= still_high_r);
    timeout   = CMP_W'(tick_count_r) > CMP_W'(phase_timeout_r);
    hold_done = CMP_W'(tick_count_r) > CMP_W'(still_hold_r);
    enter     = 1'b0;
    phase_nxt = phase_r;
    alarm_nxt = alarm_r;
    event_nxt = 1'b0;
    mag_nxt   = s3_mag_r;
    tick_count_nxt = tick_count_r;
    if (s3_op_r == afd_pkg::OP_CLEAR) begin
      alarm_nxt = 1'b0;
      mag_nxt   = '0;
    end else if (motion_enable_r) begin
      case (phase_r)
        PH_NORMAL: begin
          if (s3_mag_r < freefall_sq_r) begin
            phase_nxt = PH_FALL;
            enter     = 1'b1;
          end
        end
        PH_FALL: begin
          if (s3_mag_r > impact_sq_r) begin
            phase_nxt = PH_IMPACT;
            enter     = 1'b1;
          end else if (timeout) begin
            phase_nxt = PH_NORMAL;
          end
        end
        PH_IMPACT: begin
          if (in_band) begin
            phase_nxt = PH_STILL;
            enter     = 1'b1;
          end else if (timeout) begin
            phase_nxt = PH_NORMAL;
          end
        end
        default: begin
          if (hold_done) begin
            alarm_nxt = 1'b1;
            event_nxt = 1'b1;
            phase_nxt = PH_NORMAL;
          end else if (!in_band) begin
            phase_nxt = PH_NORMAL;
          end
        end
      endcase
      if (enter) begin
        tick_count_nxt = CNT_ONE;
      end else if (tick_count_r != CNT_MAX) begin
        tick_count_nxt = tick_count_r + CNT_ONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_NORMAL;
      tick_count_r <= '0;
      alarm_r      <= 1'b0;
      out_v_r      <= 1'b0;
    end else if (out_rdy) begin
      out_v_r <= s3_v_r;
      if (s3_v_r) begin
        phase_r      <= phase_nxt;
        tick_count_r <= tick_count_nxt;
        alarm_r      <= alarm_nxt;
        out_r.phase      <= phase_nxt;
        out_r.fall_alarm <= alarm_nxt;
        out_r.fall_event <= event_nxt;
        out_r.mag_sq     <= mag_nxt;
      end
    end
  end

  assign out_ch.valid = out_v_r;
  assign out_ch.data  = out_r;

  // checks
  a_event_alarm: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_r.fall_event |-> out_r.fall_alarm && out_r.phase == PH_NORMAL)
    else $error("fall event without alarm or normal phase");

  a_clear_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_rdy && s3_v_r && s3_op_r == afd_pkg::OP_CLEAR
      |=> !out_r.fall_alarm && out_r.mag_sq == '0 && !out_r.fall_event)
    else $error("clear beat left alarm or magnitude");

  a_enter_fall: assert property (@(posedge clk) disable iff (!rst_n)
    out_rdy && s3_v_r && phase_r == PH_NORMAL && phase_nxt == PH_FALL
      |=> tick_count_r == CNT_ONE)
    else $error("counter not restarted on free fall entry");

  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_rdy && s3_v_r) |=> $stable(phase_r) && $stable(tick_count_r) && $stable(alarm_r))
    else $error("phase state moved without a beat");

endmodule

### sim/afd_fall_checker.sv
module afd_fall_checker #(
  parameter int COUNT_W = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  afd_pkg::in_beat_t              in_data,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  afd_pkg::out_beat_t             out_data,
  input  logic                           cfg_we,
  input  logic [afd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [afd_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             fail_count,
  output int                             pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {
    PHASE_NORMAL    = 2'd0,
    PHASE_FREE_FALL = 2'd1,
    PHASE_IMPACT    = 2'd2,
    PHASE_STILL     = 2'd3
  } fall_phase_t;

  logic                        motion_on;
  logic [afd_pkg::LIMIT_W-1:0] ff_limit;
  logic [afd_pkg::LIMIT_W-1:0] impact_limit;
  logic [afd_pkg::LIMIT_W-1:0] band_low;
  logic [afd_pkg::LIMIT_W-1:0] band_high;
  logic [afd_pkg::TICK_W-1:0]  timeout_ticks;
  logic [afd_pkg::TICK_W-1:0]  hold_ticks;

  fall_phase_t        cur_phase;
  logic [COUNT_W-1:0] tick_cnt;
  logic               alarm_on;

  afd_pkg::out_beat_t expected_q[$];

  function automatic afd_pkg::out_beat_t step_detector(afd_pkg::in_beat_t b);
    afd_pkg::out_beat_t r;
    logic signed [31:0] ax, ay, az;
    logic [afd_pkg::MAG_W-1:0] mag;
    logic in_band;
    r = '0;
    if (b.op == afd_pkg::OP_CLEAR) begin
      alarm_on = 1'b0;
    end else begin
      ax = b.accel_x;
      ay = b.accel_y;
      az = b.accel_z;
      mag = $unsigned(ax * ax) + $unsigned(ay * ay) + $unsigned(az * az);
      r.mag_sq = mag;
      if (motion_on) begin
        in_band = (mag >= band_low) && (mag <= band_high);
        case (cur_phase)
          PHASE_NORMAL: begin
            if (mag < ff_limit) begin
              cur_phase = PHASE_FREE_FALL;
              tick_cnt = '0;
            end
          end
          PHASE_FREE_FALL: begin
            if (mag > impact_limit) begin
              cur_phase = PHASE_IMPACT;
              tick_cnt = '0;
            end else if (tick_cnt > timeout_ticks) begin
              cur_phase = PHASE_NORMAL;
            end
          end
          PHASE_IMPACT: begin
            if (in_band) begin
              cur_phase = PHASE_STILL;
              tick_cnt = '0;
            end else if (tick_cnt > timeout_ticks) begin
              cur_phase = PHASE_NORMAL;
            end
          end
          default: begin
            // alarm check wins over leaving the still band
            if (tick_cnt > hold_ticks) begin
              alarm_on = 1'b1;
              r.fall_event = 1'b1;
              cur_phase = PHASE_NORMAL;
            end else if (!in_band) begin
              cur_phase = PHASE_NORMAL;
            end
          end
        endcase
        if (tick_cnt != '1) tick_cnt++;
      end
    end
    r.phase = cur_phase;
    r.fall_alarm = alarm_on;
    return r;
  endfunction

  always @(posedge clk) begin
    afd_pkg::out_beat_t want;
    if (!rst_n) begin
      motion_on = afd_pkg::RST_MOTION_ENABLE;
      ff_limit = afd_pkg::RST_FREEFALL_SQ;
      impact_limit = afd_pkg::RST_IMPACT_SQ;
      band_low = afd_pkg::RST_STILL_SQ_LOW;
      band_high = afd_pkg::RST_STILL_SQ_HIGH;
      timeout_ticks = afd_pkg::RST_PHASE_TIMEOUT;
      hold_ticks = afd_pkg::RST_STILL_HOLD;
      cur_phase = PHASE_NORMAL;
      tick_cnt = '0;
      alarm_on = 1'b0;
      expected_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          afd_pkg::REG_MOTION_ENABLE: motion_on = cfg_data[0];
          afd_pkg::REG_FREEFALL_SQ:   ff_limit = cfg_data;
          afd_pkg::REG_IMPACT_SQ:     impact_limit = cfg_data;
          afd_pkg::REG_STILL_SQ_LOW:  band_low = cfg_data;
          afd_pkg::REG_STILL_SQ_HIGH: band_high = cfg_data;
          afd_pkg::REG_PHASE_TIMEOUT: timeout_ticks = cfg_data[afd_pkg::TICK_W-1:0];
          afd_pkg::REG_STILL_HOLD:    hold_ticks = cfg_data[afd_pkg::TICK_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $error("result beat with nothing expected");
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          if (out_data.phase !== want.phase) begin
            $error("phase: expected %0d, got %0d", want.phase, out_data.phase);
            fail_count++;
          end
          if (out_data.fall_alarm !== want.fall_alarm) begin
            $error("fall_alarm: expected %0d, got %0d", want.fall_alarm, out_data.fall_alarm);
            fail_count++;
          end
          if (out_data.fall_event !== want.fall_event) begin
            $error("fall_event: expected %0d, got %0d", want.fall_event, out_data.fall_event);
            fail_count++;
          end
          if (out_data.mag_sq !== want.mag_sq) begin
            $error("mag_sq: expected %0d, got %0d", want.mag_sq, out_data.mag_sq);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) expected_q.push_back(step_detector(in_data));
    end
    pending = expected_q.size();
  end

endmodule

### sim/accel_fall_detector_test.sv
module accel_fall_detector_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [afd_pkg::CFG_IDX_W-1:0] REG_SPARE = 3'd7;
  localparam logic [31:0] SQ_TOP = 32'hC000_0000;
  localparam int CYCLE_LIMIT = 100_000;
  localparam int BEATS_PER_PHASE = 160;
  localparam int PARK_BEATS = 300;

  typedef enum {K_QUIET, K_HARD, K_REST, K_ANY} accel_kind_t;

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           cfg_we;
  logic [afd_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [afd_pkg::CFG_DATA_W-1:0] cfg_data;

  int fail_count;
  int pending;
  int cycle_cnt = 0;
  int beats_sent = 0;
  int stall_asks = 0;
  bit idle_on = 1'b1;
  logic [afd_pkg::TICK_W-1:0] cur_timeout;
  logic [afd_pkg::TICK_W-1:0] cur_hold;

  afd_chan_if #(.data_t(afd_pkg::in_beat_t))  in_ch ();
  afd_chan_if #(.data_t(afd_pkg::out_beat_t)) out_ch ();

  accel_fall_detector u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  afd_fall_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_data    (in_ch.data),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_data   (out_ch.data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver: random stalls plus one long hold-off on request
  initial begin
    int hold_left;
    int stall_seen;
    hold_left = 0;
    stall_seen = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_asks != stall_seen) begin
        stall_seen = stall_asks;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= !(idle_on && $urandom_range(0, 99) < 22);
      end
    end
  end

  function automatic afd_pkg::in_beat_t sample_beat(int x, int y, int z);
    afd_pkg::in_beat_t b;
    b.op = afd_pkg::OP_SAMPLE;
    b.accel_x = 16'(x);
    b.accel_y = 16'(y);
    b.accel_z = 16'(z);
    return b;
  endfunction

  function automatic afd_pkg::in_beat_t clear_beat();
    afd_pkg::in_beat_t b;
    b = sample_beat($urandom, $urandom, $urandom);
    b.op = afd_pkg::OP_CLEAR;
    return b;
  endfunction

  function automatic afd_pkg::in_beat_t rand_sample(accel_kind_t kind);
    int v[3];
    int hot;
    hot = $urandom_range(0, 2);
    for (int i = 0; i < 3; i++) begin
      case (kind)
        K_QUIET: v[i] = int'($urandom_range(0, 600)) - 300;
        K_HARD: v[i] = (i == hot) ? int'($urandom_range(20000, 32767))
                                   : int'($urandom_range(0, 4000)) - 2000;
        K_REST: v[i] = (i == hot) ? int'($urandom_range(3700, 4600))
                                   : int'($urandom_range(0, 400)) - 200;
        default: v[i] = int'($urandom);
      endcase
      if (kind inside {K_HARD, K_REST} && i == hot && $urandom_range(0, 1)) v[i] = -v[i];
    end
    return sample_beat(v[0], v[1], v[2]);
  endfunction

  // valid stays up between back-to-back beats
  task automatic send_beat(input afd_pkg::in_beat_t b);
    if (idle_on) begin
      while ($urandom_range(0, 99) < 22) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    beats_sent++;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic put_reg(input logic [afd_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic load_regs(input logic [31:0] en, input logic [31:0] ff,
                           input logic [31:0] imp, input logic [31:0] lo,
                           input logic [31:0] hi, input logic [31:0] tmo,
                           input logic [31:0] hld);
    drain();
    put_reg(afd_pkg::REG_MOTION_ENABLE, en);
    put_reg(afd_pkg::REG_FREEFALL_SQ, ff);
    put_reg(afd_pkg::REG_IMPACT_SQ, imp);
    put_reg(afd_pkg::REG_STILL_SQ_LOW, lo);
    put_reg(afd_pkg::REG_STILL_SQ_HIGH, hi);
    put_reg(afd_pkg::REG_PHASE_TIMEOUT, tmo);
    put_reg(afd_pkg::REG_STILL_HOLD, hld);
    put_reg(REG_SPARE, $urandom);
    cfg_we <= 1'b0;
    cur_timeout = tmo[afd_pkg::TICK_W-1:0];
    cur_hold = hld[afd_pkg::TICK_W-1:0];
  endtask

  // one fall-shaped run: drop, then mostly a hit and rest, with noise and an occasional clear mixed in
  task automatic send_fall_run();
    int tmo;
    int hld;
    tmo = (cur_timeout > 8) ? 8 : cur_timeout;
    hld = (cur_hold > 10) ? 10 : cur_hold;
    repeat ($urandom_range(0, 2)) send_beat(rand_sample(K_ANY));
    send_beat(rand_sample(K_QUIET));
    repeat ($urandom_range(0, tmo + 1)) send_beat(rand_sample(K_QUIET));
    if ($urandom_range(0, 99) < 85) begin
      send_beat(rand_sample(K_HARD));
      if ($urandom_range(0, 4) == 0)
        repeat ($urandom_range(0, tmo + 1)) send_beat(rand_sample(K_QUIET));
      repeat ($urandom_range(0, hld + 3))
        send_beat(rand_sample(($urandom_range(0, 19) == 0) ? K_ANY : K_REST));
    end
    if ($urandom_range(0, 9) == 0) send_beat(clear_beat());
  endtask

  initial begin
    int phase_start;
    bit asked;
    bit paused;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    cur_timeout = afd_pkg::RST_PHASE_TIMEOUT;
    cur_hold = afd_pkg::RST_STILL_HOLD;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // short timers, upper bits of the timeout set to check masking
    load_regs(afd_pkg::RST_MOTION_ENABLE, afd_pkg::RST_FREEFALL_SQ, afd_pkg::RST_IMPACT_SQ,
              afd_pkg::RST_STILL_SQ_LOW, afd_pkg::RST_STILL_SQ_HIGH,
              32'hABCD_0002, 32'h0000_0003);
    send_beat(sample_beat(0, 0, 0));
    send_beat(sample_beat(-32768, -32768, -32768));
    send_beat(sample_beat(4096, 0, 0));
    repeat (4) send_beat(sample_beat(0, -4096, 0));
    send_beat(sample_beat(32767, 32767, 32767));
    send_beat(sample_beat(0, 0, 0));
    send_beat(sample_beat(32767, 0, 0));
    send_beat(sample_beat(0, 0, 4096));
    // alarm fires again while still set
    repeat (4) send_beat(sample_beat(0, 0, -4096));

    // motion off: samples ignored, clear still drops the alarm
    load_regs(32'hFFFF_FFFE, afd_pkg::RST_FREEFALL_SQ, afd_pkg::RST_IMPACT_SQ,
              afd_pkg::RST_STILL_SQ_LOW, afd_pkg::RST_STILL_SQ_HIGH, 32'd2, 32'd3);
    send_beat(sample_beat(0, 0, 0));
    send_beat(clear_beat());

    load_regs(afd_pkg::RST_MOTION_ENABLE, afd_pkg::RST_FREEFALL_SQ, afd_pkg::RST_IMPACT_SQ,
              afd_pkg::RST_STILL_SQ_LOW, afd_pkg::RST_STILL_SQ_HIGH, 32'd2, 32'd3);
    send_beat(sample_beat(0, 0, 0));
    repeat (3) send_beat(sample_beat(0, 0, 4096));
    send_beat(sample_beat(0, 0, 0));
    send_beat(sample_beat(-20000, 0, 0));
    send_beat(sample_beat(4096, 0, 0));
    send_beat(sample_beat(100, 100, 100));

    // long park in free fall under a wide timeout, then shorten the timeout
    idle_on = 1'b0;
    load_regs(afd_pkg::RST_MOTION_ENABLE, afd_pkg::RST_FREEFALL_SQ, afd_pkg::RST_IMPACT_SQ,
              afd_pkg::RST_STILL_SQ_LOW, afd_pkg::RST_STILL_SQ_HIGH,
              32'h0000_FFFF, afd_pkg::RST_STILL_HOLD);
    send_beat(sample_beat(0, 0, 0));
    repeat (PARK_BEATS) send_beat(sample_beat(0, 4096, 0));
    load_regs(afd_pkg::RST_MOTION_ENABLE, afd_pkg::RST_FREEFALL_SQ, afd_pkg::RST_IMPACT_SQ,
              afd_pkg::RST_STILL_SQ_LOW, afd_pkg::RST_STILL_SQ_HIGH,
              32'd5, afd_pkg::RST_STILL_HOLD);
    send_beat(sample_beat(0, 4096, 0));

    for (int p = 0; p < 8; p++) begin
      idle_on = (p != 1);
      case (p)
        2: load_regs(32'd0, $urandom_range(0, SQ_TOP), $urandom_range(0, SQ_TOP),
                     $urandom_range(0, SQ_TOP), $urandom_range(0, SQ_TOP),
                     $urandom_range(0, 6), $urandom_range(0, 6));
        3: load_regs(afd_pkg::RST_MOTION_ENABLE, SQ_TOP, 32'd0, 32'd0, SQ_TOP, 32'd0, 32'd0);
        4: load_regs(afd_pkg::RST_MOTION_ENABLE, 32'd0, SQ_TOP, SQ_TOP, 32'd0,
                     32'h0000_FFFF, 32'h0000_FFFF);
        5: load_regs(afd_pkg::RST_MOTION_ENABLE, $urandom_range(0, SQ_TOP),
                     $urandom_range(0, SQ_TOP), $urandom_range(0, SQ_TOP),
                     $urandom_range(0, SQ_TOP), $urandom_range(0, 10),
                     $urandom_range(0, 10));
        default: load_regs(afd_pkg::RST_MOTION_ENABLE, afd_pkg::RST_FREEFALL_SQ,
                           afd_pkg::RST_IMPACT_SQ, afd_pkg::RST_STILL_SQ_LOW,
                           afd_pkg::RST_STILL_SQ_HIGH,
                           $urandom_range(0, 6), $urandom_range(0, 6));
      endcase
      phase_start = beats_sent;
      asked = 1'b0;
      paused = 1'b0;
      while (beats_sent - phase_start < BEATS_PER_PHASE) begin
        if (p == 6 && !asked && beats_sent - phase_start > 50) begin
          stall_asks++;
          asked = 1'b1;
        end
        if (p == 7 && !paused && beats_sent - phase_start > 100) begin
          drain();
          paused = 1'b1;
        end
        send_fall_run();
      end
    end

    drain();
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
